/* rtl/adsr_envelope_generator_macros.svh */
// Assertion macros shared by the envelope generator modules.
// Each macro expects aclk and aresetn to be visible in the module that uses it.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/adsr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and control types of the envelope generator.
// No dependencies; used by the controller, the datapath and the top level.
package adsr_pkg;

    localparam int TIME_BITS  = 32;
    localparam int SAMPLE_W   = 32;
    localparam int ACTION_W   = 2;
    localparam int LEN_W      = 20;
    localparam int LVL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W     = LEN_W + LVL_W;
    localparam int DIV_STEPS  = LVL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CMP_W      = (TIME_BITS > LEN_W + 1) ? TIME_BITS : LEN_W + 1;

    localparam logic [LVL_W-1:0] LEVEL_ONE   = LVL_W'(32768);
    localparam logic [LVL_W-1:0] FLOOR_LEVEL = LVL_W'(4);

    localparam logic [LEN_W-1:0] ATTACK_RESET  = LEN_W'(4410);
    localparam logic [LEN_W-1:0] DECAY_RESET   = LEN_W'(441);
    localparam logic [LEN_W-1:0] RELEASE_RESET = LEN_W'(8820);
    localparam logic [LVL_W-1:0] PEAK_RESET    = LVL_W'(32768);
    localparam logic [LVL_W-1:0] HOLD_RESET    = LVL_W'(26214);

    localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEVEL  = 3'd4;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ELAPSED = 6'b000010,
        ST_SELECT  = 6'b000100,
        ST_MUL     = 6'b001000,
        ST_DIV     = 6'b010000,
        ST_FINISH  = 6'b100000
    } adsr_state_t;

    typedef struct packed {
        logic capture;
        logic elapsed;
        logic select;
        logic multiply;
        logic div_step;
        logic finish;
    } adsr_cmd_t;

    typedef struct packed {
        logic last_step;
    } adsr_status_t;

endpackage

/* rtl/adsr_envelope_generator.sv */
`timescale 1ns / 1ps
// Top level of the linear ADSR envelope generator.
// Depends on adsr_pkg, adsr_ctrl and adsr_dp.
//
// Usage:
// Each input item (s_action, s_sample_time) returns one item on m_amplitude,
// the Q1.15 envelope level at that time after the note on or note off.
// s_ready is high only while no item is being worked on. An accepted item
// passes elapsed time, phase select, one multiply and a 16-step restoring
// divide before its result shows on m_valid. The next item is accepted
// only once the controller is back in idle, so the block does not take a
// new item before it is through with the last one.
// The result sits in an output register: a new item is accepted while it
// waits, but that item's result is held back until m_ready takes the old one.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready stays high) and belong in idle periods; index 5 and up is ignored.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the note-held flag and both time stamps, and drops m_valid.
module adsr_envelope_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [adsr_pkg::ACTION_W-1:0]       s_action,
    input  logic [adsr_pkg::SAMPLE_W-1:0]       s_sample_time,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [adsr_pkg::LVL_W-1:0]          m_amplitude,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    adsr_pkg::adsr_cmd_t    cmd;
    adsr_pkg::adsr_status_t status;

    assign cfg_ready = 1'b1;

    adsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    adsr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_action      (s_action),
        .s_sample_time (s_sample_time),
        .cmd           (cmd),
        .status        (status),
        .m_amplitude   (m_amplitude)
    );

endmodule

/* rtl/adsr_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the envelope generator: handshakes and datapath commands.
// Depends on adsr_pkg and the assertion macro header.
`include "adsr_envelope_generator_macros.svh"

module adsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  adsr_pkg::adsr_status_t status,
    output adsr_pkg::adsr_cmd_t  cmd
);

    adsr_pkg::adsr_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == adsr_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.capture  = (state_reg == adsr_pkg::ST_IDLE) && s_valid;
        cmd.elapsed  = (state_reg == adsr_pkg::ST_ELAPSED);
        cmd.select   = (state_reg == adsr_pkg::ST_SELECT);
        cmd.multiply = (state_reg == adsr_pkg::ST_MUL);
        cmd.div_step = (state_reg == adsr_pkg::ST_DIV);
        cmd.finish   = (state_reg == adsr_pkg::ST_FINISH) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            adsr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = adsr_pkg::ST_ELAPSED;
                end
            end
            adsr_pkg::ST_ELAPSED: begin
                state_next = adsr_pkg::ST_SELECT;
            end
            adsr_pkg::ST_SELECT: begin
                state_next = adsr_pkg::ST_MUL;
            end
            adsr_pkg::ST_MUL: begin
                state_next = adsr_pkg::ST_DIV;
            end
            adsr_pkg::ST_DIV: begin
                if (status.last_step) begin
                    state_next = adsr_pkg::ST_FINISH;
                end
            end
            adsr_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = adsr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = adsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= adsr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ADSR_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `ADSR_ASSERT_NEXT(a_finish_waits,
        state_reg == adsr_pkg::ST_FINISH && out_valid_reg && !m_ready,
        state_reg == adsr_pkg::ST_FINISH && m_valid, "finished item lost under stall")
    `ADSR_ASSERT_IMPLIES(a_div_complete,
        state_reg == adsr_pkg::ST_FINISH && $past(state_reg) != adsr_pkg::ST_FINISH,
        $past(status.last_step), "division left before its last step")

endmodule

/* rtl/adsr_dp.sv */
`timescale 1ns / 1ps
// Datapath of the envelope generator: registers, note state, phase select,
// multiplier and a radix-2 restoring divider. Depends on adsr_pkg and the macros.
`include "adsr_envelope_generator_macros.svh"

module adsr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [adsr_pkg::ACTION_W-1:0]       s_action,
    input  logic [adsr_pkg::SAMPLE_W-1:0]       s_sample_time,
    input  adsr_pkg::adsr_cmd_t                 cmd,
    output adsr_pkg::adsr_status_t              status,
    output logic [adsr_pkg::LVL_W-1:0]          m_amplitude
);

    logic [adsr_pkg::LEN_W-1:0] attack_len_reg, decay_len_reg, release_len_reg;
    logic [adsr_pkg::LVL_W-1:0] peak_level_reg, hold_level_reg;

    logic                           held_reg;
    logic [adsr_pkg::TIME_BITS-1:0] start_reg, release_reg, now_reg, e_reg;
    logic [adsr_pkg::TIME_BITS-1:0] stamp;

    logic [adsr_pkg::LEN_W-1:0] a_eff, d_eff, r_eff;
    logic [adsr_pkg::LVL_W-1:0] pk_eff, hd_eff;
    logic [adsr_pkg::CMP_W-1:0] e_x, a_x, ad_x, r_x, de_x;

    logic [adsr_pkg::LEN_W-1:0] mul_a_reg, mul_a_next, div_reg, div_next;
    logic [adsr_pkg::LVL_W-1:0] mul_b_reg, mul_b_next, base_reg, base_next;
    logic                       sub_reg, sub_next;

    logic [adsr_pkg::PROD_W-1:0]  product;
    logic [adsr_pkg::LEN_W-1:0]   rem_reg;
    logic [adsr_pkg::LVL_W-1:0]   quo_reg;
    logic [adsr_pkg::LEN_W+1:0]   trial;
    logic [adsr_pkg::STEP_W-1:0]  step_reg;
    logic [adsr_pkg::LVL_W-1:0]   level_sum;
    logic [adsr_pkg::LVL_W-1:0]   amp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg  <= adsr_pkg::ATTACK_RESET;
            decay_len_reg   <= adsr_pkg::DECAY_RESET;
            release_len_reg <= adsr_pkg::RELEASE_RESET;
            peak_level_reg  <= adsr_pkg::PEAK_RESET;
            hold_level_reg  <= adsr_pkg::HOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                adsr_pkg::REG_ATTACK_LEN:  attack_len_reg  <= cfg_data;
                adsr_pkg::REG_DECAY_LEN:   decay_len_reg   <= cfg_data;
                adsr_pkg::REG_RELEASE_LEN: release_len_reg <= cfg_data;
                adsr_pkg::REG_PEAK_LEVEL:  peak_level_reg  <= cfg_data[adsr_pkg::LVL_W-1:0];
                adsr_pkg::REG_HOLD_LEVEL:  hold_level_reg  <= cfg_data[adsr_pkg::LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 1'b0;
            start_reg   <= '0;
            release_reg <= '0;
        end else if (cmd.capture) begin
            unique case (s_action)
                adsr_pkg::ACT_NOTE_ON: begin
                    held_reg  <= 1'b1;
                    start_reg <= adsr_pkg::TIME_BITS'(s_sample_time);
                end
                adsr_pkg::ACT_NOTE_OFF: begin
                    held_reg    <= 1'b0;
                    release_reg <= adsr_pkg::TIME_BITS'(s_sample_time);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg <= adsr_pkg::TIME_BITS'(s_sample_time);
        end
        if (cmd.elapsed) begin
            e_reg <= (now_reg >= stamp) ? now_reg - stamp : '0;
        end
    end

    assign stamp = held_reg ? start_reg : release_reg;

    assign a_eff  = (attack_len_reg == '0) ? adsr_pkg::LEN_W'(1) : attack_len_reg;
    assign d_eff  = (decay_len_reg == '0) ? adsr_pkg::LEN_W'(1) : decay_len_reg;
    assign r_eff  = (release_len_reg == '0) ? adsr_pkg::LEN_W'(1) : release_len_reg;
    assign pk_eff = (peak_level_reg > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE
                                                            : peak_level_reg;
    assign hd_eff = (hold_level_reg > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE
                                                            : hold_level_reg;

    assign e_x  = adsr_pkg::CMP_W'(e_reg);
    assign a_x  = adsr_pkg::CMP_W'(a_eff);
    assign ad_x = adsr_pkg::CMP_W'(a_eff) + adsr_pkg::CMP_W'(d_eff);
    assign r_x  = adsr_pkg::CMP_W'(r_eff);
    assign de_x = e_x - a_x;

    // Every phase is reduced to base +/- floor(mul_a * mul_b / div).
    always_comb begin
        mul_a_next = '0;
        mul_b_next = '0;
        div_next   = adsr_pkg::LEN_W'(1);
        base_next  = '0;
        sub_next   = 1'b0;
        if (held_reg) begin
            priority if (e_x <= a_x) begin
                mul_a_next = e_x[adsr_pkg::LEN_W-1:0];
                mul_b_next = pk_eff;
                div_next   = a_eff;
            end else if (e_x <= ad_x) begin
                mul_a_next = de_x[adsr_pkg::LEN_W-1:0];
                div_next   = d_eff;
                base_next  = pk_eff;
                if (hd_eff >= pk_eff) begin
                    mul_b_next = hd_eff - pk_eff;
                end else begin
                    mul_b_next = pk_eff - hd_eff;
                    sub_next   = 1'b1;
                end
            end else begin
                base_next = hd_eff;
            end
        end else if (e_x < r_x) begin
            mul_a_next = e_x[adsr_pkg::LEN_W-1:0];
            mul_b_next = hd_eff;
            div_next   = r_eff;
            base_next  = hd_eff;
            sub_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.select) begin
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
            div_reg   <= div_next;
            base_reg  <= base_next;
            sub_reg   <= sub_next;
        end
    end

    assign product = adsr_pkg::PROD_W'(mul_a_reg) * adsr_pkg::PROD_W'(mul_b_reg);

    // The quotient never exceeds one in Q1.15, so the upper product bits start
    // below the divisor and one quotient bit per step suffices.
    assign trial = {1'b0, rem_reg, quo_reg[adsr_pkg::LVL_W-1]} - {2'b00, div_reg};

    always_ff @(posedge aclk) begin
        if (cmd.multiply) begin
            rem_reg <= product[adsr_pkg::PROD_W-1:adsr_pkg::LVL_W];
            quo_reg <= product[adsr_pkg::LVL_W-1:0];
        end else if (cmd.div_step) begin
            if (!trial[adsr_pkg::LEN_W+1]) begin
                rem_reg <= trial[adsr_pkg::LEN_W-1:0];
                quo_reg <= {quo_reg[adsr_pkg::LVL_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[adsr_pkg::LEN_W-2:0], quo_reg[adsr_pkg::LVL_W-1]};
                quo_reg <= {quo_reg[adsr_pkg::LVL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.multiply) begin
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + adsr_pkg::STEP_W'(1);
        end
    end

    assign status.last_step = (step_reg == adsr_pkg::STEP_W'(adsr_pkg::DIV_STEPS - 1));

    assign level_sum = sub_reg ? base_reg - quo_reg : base_reg + quo_reg;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            amp_reg <= (level_sum < adsr_pkg::FLOOR_LEVEL) ? '0 : level_sum;
        end
    end

    assign m_amplitude = amp_reg;

    `ADSR_ASSERT_IMPLIES(a_rem_below_div, cmd.div_step, rem_reg < div_reg,
        "divider remainder not below divisor")
    `ADSR_ASSERT_IMPLIES(a_level_in_range, cmd.finish, level_sum <= adsr_pkg::LEVEL_ONE,
        "envelope level above one")

endmodule

/* dv/adsr_envelope_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the linear ADSR envelope generator.
// Depends on adsr_pkg and adsr_envelope_generator; predicts every amplitude in-line.
module adsr_envelope_generator_tb;
    import adsr_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam int MAX_IDLE      = 18;
    localparam int SETTLE_CYCLES = 25;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 250;

    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_WRITE,
        ENT_PAUSE
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t            kind;
        logic [ACTION_W-1:0]    act;
        logic [SAMPLE_W-1:0]    tick;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } pending_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [ACTION_W-1:0]    s_action;
    logic [SAMPLE_W-1:0]    s_sample_time;
    logic                   m_valid;
    logic                   m_ready;
    logic [LVL_W-1:0]       m_amplitude;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    adsr_envelope_generator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sample_time (s_sample_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_amplitude   (m_amplitude),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the envelope settings and note state.
    logic [LEN_W-1:0] attack_ticks  = ATTACK_RESET;
    logic [LEN_W-1:0] decay_ticks   = DECAY_RESET;
    logic [LEN_W-1:0] release_ticks = RELEASE_RESET;
    logic [LVL_W-1:0] peak_q15      = PEAK_RESET;
    logic [LVL_W-1:0] sustain_q15   = HOLD_RESET;
    logic             key_down      = 1'b0;
    logic [63:0]      attack_origin = '0;
    logic [63:0]      release_origin = '0;

    pending_t         pending[$];
    logic [LVL_W-1:0] due_amplitudes[$];

    int  items_sent = 0;
    int  items_taken = 0;
    int  writes_sent = 0;
    int  writes_taken = 0;
    int  results_seen = 0;
    int  results_looked = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  settle_left = SETTLE_CYCLES;
    int  stall_left = 0;
    bit  calm_tx = 1'b0;
    bit  calm_rx = 1'b0;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [LVL_W-1:0] envelope_step(input logic [ACTION_W-1:0] act,
                                                       input logic [SAMPLE_W-1:0] tick);
        logic [63:0] now, e, a, d, r, pk, hd, amp;
        now = 64'(tick) & ((64'd1 << TIME_BITS) - 64'd1);
        if (act == ACT_NOTE_ON) begin
            attack_origin = now;
            key_down = 1'b1;
        end else if (act == ACT_NOTE_OFF) begin
            release_origin = now;
            key_down = 1'b0;
        end
        a  = (attack_ticks == '0) ? 64'd1 : 64'(attack_ticks);
        d  = (decay_ticks == '0) ? 64'd1 : 64'(decay_ticks);
        r  = (release_ticks == '0) ? 64'd1 : 64'(release_ticks);
        pk = (peak_q15 > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(peak_q15);
        hd = (sustain_q15 > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(sustain_q15);
        if (key_down) begin
            e = (now >= attack_origin) ? now - attack_origin : 64'd0;
            if (e <= a) begin
                amp = e * pk / a;
            end else if (e <= a + d) begin
                if (hd >= pk) begin
                    amp = pk + (e - a) * (hd - pk) / d;
                end else begin
                    amp = pk - (e - a) * (pk - hd) / d;
                end
            end else begin
                amp = hd;
            end
        end else begin
            e = (now >= release_origin) ? now - release_origin : 64'd0;
            amp = (e >= r) ? 64'd0 : hd - e * hd / r;
        end
        if (amp < 64'(FLOOR_LEVEL)) begin
            amp = 64'd0;
        end
        return amp[LVL_W-1:0];
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_ATTACK_LEN:  attack_ticks = val[LEN_W-1:0];
            REG_DECAY_LEN:   decay_ticks = val[LEN_W-1:0];
            REG_RELEASE_LEN: release_ticks = val[LEN_W-1:0];
            REG_PEAK_LEVEL:  peak_q15 = val[LVL_W-1:0];
            REG_HOLD_LEVEL:  sustain_q15 = val[LVL_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic queue_sample(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] tick);
        pending.push_back('{kind: ENT_ITEM, act: act, tick: tick, reg_idx: '0, reg_val: '0});
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        pending.push_back('{kind: ENT_WRITE, act: ACT_SAMPLE, tick: '0, reg_idx: idx,
                            reg_val: val});
    endtask

    task automatic queue_pause();
        pending.push_back('{kind: ENT_PAUSE, act: ACT_SAMPLE, tick: '0, reg_idx: '0,
                            reg_val: '0});
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                due_amplitudes.push_back(envelope_step(s_action, s_sample_time));
                items_taken++;
            end
            if (cfg_valid && cfg_ready) begin
                store_register(cfg_index, cfg_data);
                writes_taken++;
            end
            if (m_valid && m_ready) begin
                if (due_amplitudes.size() == 0) begin
                    $display("%0t: amplitude with nothing expected, expected none, actual %0d",
                             $time, m_amplitude);
                    mismatches++;
                end else if (due_amplitudes[0] !== m_amplitude) begin
                    $display("%0t: amplitude mismatch, expected %0d, actual %0d",
                             $time, due_amplitudes[0], m_amplitude);
                    mismatches++;
                    void'(due_amplitudes.pop_front());
                end else begin
                    void'(due_amplitudes.pop_front());
                end
                results_seen++;
            end
        end
    end

    always @(negedge aclk) begin
        pending_t head;
        logic     item_up;
        logic     write_up;
        item_up = s_valid && (items_sent != items_taken);
        write_up = cfg_valid && (writes_sent != writes_taken);
        if (due_amplitudes.size() != 0 || item_up || write_up) begin
            settle_left = SETTLE_CYCLES;
        end
        if (aresetn && !item_up && !write_up && pending.size() != 0) begin
            head = pending[0];
            if (head.kind == ENT_ITEM) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    s_action <= head.act;
                    s_sample_time <= head.tick;
                    item_up = 1'b1;
                    items_sent++;
                    void'(pending.pop_front());
                    if ($urandom_range(0, 47) == 0) begin
                        calm_tx = !calm_tx;
                    end
                    gap_left = calm_tx ? 0 : $urandom_range(0, MAX_IDLE);
                end
            end else if (settle_left != 0) begin
                settle_left--;
            end else begin
                if (head.kind == ENT_WRITE) begin
                    cfg_index <= head.reg_idx;
                    cfg_data <= head.reg_val;
                    write_up = 1'b1;
                    writes_sent++;
                end
                void'(pending.pop_front());
            end
        end
        s_valid <= item_up;
        cfg_valid <= write_up;
    end

    always @(negedge aclk) begin
        if (results_seen != results_looked) begin
            results_looked = results_seen;
            if ($urandom_range(0, 47) == 0) begin
                calm_rx = !calm_rx;
            end
            stall_left = calm_rx ? 0 : $urandom_range(0, MAX_IDLE);
        end
        if (stall_left == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            if (m_valid) begin
                stall_left--;
            end
        end
    end

    initial begin
        #6000000;
        $display("adsr_envelope_generator regression: fail");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] len_pick[3];
        logic [CFG_DATA_W-1:0] lvl_pick[2];
        logic [SAMPLE_W-1:0]   t;
        int unsigned           span_on;
        int unsigned           span_off;
        int unsigned           eff[3];
        int                    made;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_SAMPLE;
        s_sample_time = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ATTACK_LEN;
        cfg_data = '0;

        // Power-up settings: release from time zero, then a full note.
        queue_sample(ACT_SAMPLE, 32'd0);
        queue_sample(ACT_SAMPLE, 32'd4000);
        queue_sample(ACT_UNKNOWN, 32'd9000);
        queue_sample(ACT_NOTE_ON, 32'd10000);
        queue_sample(ACT_SAMPLE, 32'd12205);
        queue_sample(ACT_SAMPLE, 32'd14410);
        queue_sample(ACT_SAMPLE, 32'd14600);
        queue_sample(ACT_SAMPLE, 32'd20000);
        queue_sample(ACT_SAMPLE, 32'd5000);
        queue_sample(ACT_NOTE_OFF, 32'd20000);
        queue_sample(ACT_SAMPLE, 32'd28819);
        queue_sample(ACT_SAMPLE, '1);
        queue_sample(ACT_NOTE_ON, '1);
        queue_sample(ACT_NOTE_OFF, 32'd0);
        queue_pause();

        // Zero lengths, the longest decay, and a peak above one.
        queue_write(REG_ATTACK_LEN, '0);
        queue_write(REG_DECAY_LEN, '1);
        queue_write(REG_RELEASE_LEN, '0);
        queue_write(REG_PEAK_LEVEL, '1);
        queue_write(REG_HOLD_LEVEL, '0);
        queue_sample(ACT_NOTE_ON, 32'd100);
        queue_sample(ACT_SAMPLE, 32'd101);
        queue_sample(ACT_SAMPLE, 32'd102);
        queue_sample(ACT_SAMPLE, '1);
        queue_sample(ACT_NOTE_OFF, 32'd200);

        // Longest attack and release, a rising decay, and writes to unused indexes.
        queue_write(REG_ATTACK_LEN, '1);
        queue_write(REG_DECAY_LEN, '0);
        queue_write(REG_RELEASE_LEN, '1);
        queue_write(REG_PEAK_LEVEL, '0);
        queue_write(REG_HOLD_LEVEL, CFG_DATA_W'(LEVEL_ONE));
        for (int k = int'(REG_HOLD_LEVEL) + 1; k < (1 << CFG_IDX_W); k++) begin
            queue_write(CFG_IDX_W'(k), '0);
        end
        queue_sample(ACT_NOTE_ON, 32'd0);
        queue_sample(ACT_SAMPLE, 32'd1048575);
        queue_sample(ACT_SAMPLE, 32'd1048576);
        queue_sample(ACT_SAMPLE, 32'h8000_0000);
        queue_sample(ACT_NOTE_OFF, 32'h8000_0000);
        queue_sample(ACT_SAMPLE, 32'h8000_0000 + 32'd1048574);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 7))
                    0: len_pick[k] = '0;
                    1: len_pick[k] = CFG_DATA_W'(1);
                    2: len_pick[k] = '1;
                    3: len_pick[k] = CFG_DATA_W'($urandom());
                    4: len_pick[k] = CFG_DATA_W'($urandom_range(1, 5000));
                    default: len_pick[k] = CFG_DATA_W'($urandom_range(1, 300));
                endcase
                eff[k] = (len_pick[k][LEN_W-1:0] == '0) ? 1 : int'(len_pick[k][LEN_W-1:0]);
            end
            for (int k = 0; k < 2; k++) begin
                case ($urandom_range(0, 5))
                    0: lvl_pick[k] = '0;
                    1: lvl_pick[k] = CFG_DATA_W'(LEVEL_ONE);
                    2: lvl_pick[k] = CFG_DATA_W'($urandom());
                    default: lvl_pick[k] = CFG_DATA_W'($urandom_range(0, int'(LEVEL_ONE)));
                endcase
            end
            queue_write(REG_ATTACK_LEN, len_pick[0]);
            queue_write(REG_DECAY_LEN, len_pick[1]);
            queue_write(REG_RELEASE_LEN, len_pick[2]);
            queue_write(REG_PEAK_LEVEL, lvl_pick[0]);
            queue_write(REG_HOLD_LEVEL, lvl_pick[1]);
            if ($urandom_range(0, 2) == 0) begin
                queue_write(CFG_IDX_W'($urandom_range(int'(REG_HOLD_LEVEL) + 1,
                                                      (1 << CFG_IDX_W) - 1)),
                            CFG_DATA_W'($urandom()));
            end
            span_on = (eff[0] + eff[1]) / 3 + 1;
            span_off = eff[2] / 3 + 1;
            t = ($urandom_range(0, 2) == 0) ? SAMPLE_W'($urandom()) : '0;
            made = 0;
            while (made < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_sample(ACTION_W'($urandom_range(0, (1 << ACTION_W) - 1)),
                                 SAMPLE_W'($urandom()));
                    made++;
                end else begin
                    t += $urandom_range(0, span_on);
                    queue_sample(ACT_NOTE_ON, t);
                    made++;
                    repeat ($urandom_range(1, 8)) begin
                        t += $urandom_range(0, span_on);
                        queue_sample(($urandom_range(0, 15) == 0) ? ACT_UNKNOWN : ACT_SAMPLE, t);
                        made++;
                    end
                    t += $urandom_range(0, span_on);
                    queue_sample(ACT_NOTE_OFF, t);
                    made++;
                    repeat ($urandom_range(1, 6)) begin
                        t += $urandom_range(0, span_off);
                        queue_sample(ACT_SAMPLE, t);
                        made++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    queue_pause();
                end
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid || cfg_valid || due_amplitudes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d items over %0d register settings; %0d amplitudes checked.",
                 items_taken, writes_taken, results_seen);
        $display("Mismatches: %0d, amplitudes still expected: %0d.",
                 mismatches, due_amplitudes.size());
        if (mismatches == 0 && due_amplitudes.size() == 0) begin
            $display("adsr_envelope_generator regression: pass");
        end else begin
            $display("adsr_envelope_generator regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_ctrl.sv
rtl/adsr_dp.sv
rtl/adsr_envelope_generator.sv
dv/adsr_envelope_generator_tb.sv
